// File: rtl/core/bfeh_pkg.sv
`default_nettype none

package bfeh_pkg;

  // Size of the bit array. It must be a power of two, so that the reduction of a
  // hash to a bit index keeps only the low IDX_W bits.
  localparam int FILTER_BITS = 4096;
  localparam int NUM_HASHES  = 8;
  localparam int NSALT       = 8;

  localparam int IDX_W  = $clog2(FILTER_BITS);
  localparam int LANE_W = (NUM_HASHES > 1) ? $clog2(NUM_HASHES) : 1;
  localparam int SALT_W = $clog2(NSALT);
  localparam int HASH_W = 32;

  localparam logic [HASH_W-1:0] TOP_NIBBLE_MASK = 32'hF000_0000;

  // Operation codes carried with the final byte of a key.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_TEST   = 1'b1;

  typedef logic [HASH_W-1:0] hash_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              clear;       // clearing pass: write zero at clr_addr
    logic [IDX_W-1:0]  clr_addr;
    logic              load_byte;   // hash the incoming byte into every lane
    logic              key_start;   // first byte of a key: start from the salts
    logic              latch_op;    // final byte: capture the operation
    logic              start_acc;   // final byte: arm the all-set accumulator
    logic              probe;       // access the bit array for one lane
    logic [LANE_W-1:0] lane;
    logic              load_result; // move the answer into the output register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free; // output register empty or being emptied this cycle
  } dp_status_t;

  // One step of the ELF-style hash: shift in the sign-extended byte, then fold
  // the top nibble back into bits 7:4 and clear it.
  function automatic hash_t hash_byte(input hash_t h, input logic [7:0] b);
    hash_t sum;
    hash_t g;
    sum = {h[HASH_W-5:0], 4'b0000} + {{(HASH_W-8){b[7]}}, b};
    g   = sum & TOP_NIBBLE_MASK;
    return sum ^ (g >> 24) ^ g;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/bfeh_ram.sv
`default_nettype none

module bfeh_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// File: rtl/core/bfeh_dp.sv
`default_nettype none

module bfeh_dp (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire bfeh_pkg::ctrl_cmd_t         cmd,
  output bfeh_pkg::dp_status_t             status,
  input  wire logic                        cfg_we,
  input  wire logic [bfeh_pkg::SALT_W-1:0] cfg_index,
  input  wire logic [31:0]                 cfg_data,
  input  wire logic [7:0]                  key_byte,
  input  wire logic                        op_in,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             out_kind,
  output logic                             out_present
);

  bfeh_pkg::hash_t salt [bfeh_pkg::NSALT];
  bfeh_pkg::hash_t hash [bfeh_pkg::NUM_HASHES];
  logic            op;
  logic            rd_chk;
  logic            all_set;

  logic                       mem_we;
  logic                       mem_wdata;
  logic [bfeh_pkg::IDX_W-1:0] mem_addr;
  logic                       mem_rdata;

  // Salts reset to their own index.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < bfeh_pkg::NSALT; i++) begin
        salt[i] <= bfeh_pkg::HASH_W'(i);
      end
    end else if (cfg_we) begin
      salt[cfg_index] <= cfg_data;
    end
  end

  // One hash unit per lane, all updated by the same byte.
  always_ff @(posedge clk) begin
    if (cmd.load_byte) begin
      for (int i = 0; i < bfeh_pkg::NUM_HASHES; i++) begin
        hash[i] <= bfeh_pkg::hash_byte(cmd.key_start ? salt[i] : hash[i], key_byte);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_op) begin
      op <= op_in;
    end
  end

  always_comb begin
    if (cmd.clear) begin
      mem_addr  = cmd.clr_addr;
      mem_we    = 1'b1;
      mem_wdata = 1'b0;
    end else begin
      mem_addr  = hash[cmd.lane][bfeh_pkg::IDX_W-1:0];
      mem_we    = cmd.probe && (op == bfeh_pkg::OP_INSERT);
      mem_wdata = 1'b1;
    end
  end

  bfeh_ram #(
    .WIDTH (1),
    .DEPTH (bfeh_pkg::FILTER_BITS)
  ) u_bits (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // Read data of a test probe arrives in the cycle after its address.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_chk <= 1'b0;
    end else begin
      rd_chk <= cmd.probe && (op == bfeh_pkg::OP_TEST);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_acc) begin
      all_set <= 1'b1;
    end else if (rd_chk && !mem_rdata) begin
      all_set <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      out_kind    <= op;
      out_present <= (op == bfeh_pkg::OP_INSERT) || all_set;
    end
  end

  assign status.out_free = !out_valid || out_ready;

endmodule

`default_nettype wire

// File: rtl/core/bfeh_ctrl.sv
`default_nettype none

module bfeh_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire logic                 in_last,
  output logic                      in_ready,
  input  wire bfeh_pkg::dp_status_t status,
  output bfeh_pkg::ctrl_cmd_t       cmd
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PROBE,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  localparam logic [bfeh_pkg::IDX_W-1:0]  CLR_LAST  = '1;
  localparam logic [bfeh_pkg::LANE_W-1:0] LANE_LAST =
    bfeh_pkg::LANE_W'(bfeh_pkg::NUM_HASHES - 1);

  state_t                      state;
  logic [bfeh_pkg::IDX_W-1:0]  clr_addr;
  logic [bfeh_pkg::LANE_W-1:0] lane;
  logic                        key_started;
  logic                        accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_ready && in_valid;

  always_comb begin
    cmd             = '0;
    cmd.clear       = (state == ST_CLEAR);
    cmd.clr_addr    = clr_addr;
    cmd.load_byte   = accept;
    cmd.key_start   = !key_started;
    cmd.latch_op    = accept && in_last;
    cmd.start_acc   = accept && in_last;
    cmd.probe       = (state == ST_PROBE);
    cmd.lane        = lane;
    cmd.load_result = (state == ST_FINISH) && status.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_addr    <= '0;
      lane        <= '0;
      key_started <= 1'b0;
    end else begin
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + bfeh_pkg::IDX_W'(1);
          if (clr_addr == CLR_LAST) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            key_started <= !in_last;
            if (in_last) begin
              lane  <= '0;
              state <= ST_PROBE;
            end
          end
        end
        ST_PROBE: begin
          lane <= lane + bfeh_pkg::LANE_W'(1);
          if (lane == LANE_LAST) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (status.out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/bloom_filter_elf_hash_top.sv
// Bloom filter with eight salted ELF-style string hashes over a 4096-bit array.
// Keys enter on the slave stream one byte per item; tlast marks the final byte
// and tuser on that byte selects insert (0) or membership test (1).
// Each non-final byte is hashed into all eight lanes at once, so bytes of
// a key are taken at one item per cycle. The final byte is hashed likewise and
// then the eight lanes visit the single-port bit array one after another in
// the probe state; a drain state lets the last read return and a finish state
// registers the answer. The next key is taken from the cycle in which the result
// item appears; no byte is taken while a key is walked through the array, and
// the walk over the memory port sets the rate.
// The master stream carries one item per key: tuser echoes the operation and
// tdata bit 0 is the answer (always 1 for an insert).
// After reset the block clears the bit array one entry per cycle, all 4096
// entries, with tready low; salt writes are taken during that time as ever.
// Salts are written through the configuration channel, which is always ready,
// and apply from the next key. A stalled master side holds its result item;
// the whole next key, final byte included, is still taken and walked through
// the array, and its answer then waits, with tready low, until the held item
// has left.
`default_nettype none

module bloom_filter_elf_hash_top (
  input  wire logic        clk,
  input  wire logic        rst,
  // Key bytes.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // [7:0] key_byte
  input  wire logic        s_axis_tuser,  // [0] cmd
  input  wire logic        s_axis_tlast,
  // Results.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,  // [0] present, [7:1] zero
  output logic             m_axis_tuser,  // [0] op_kind
  // Salt writes.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  bfeh_pkg::ctrl_cmd_t  cmd;
  bfeh_pkg::dp_status_t status;
  logic                 present;

  assign cfg_ready = 1'b1;

  bfeh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_last  (s_axis_tlast),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  bfeh_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .key_byte    (s_axis_tdata),
    .op_in       (s_axis_tuser),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_kind    (m_axis_tuser),
    .out_present (present)
  );

  assign m_axis_tdata = {7'b0, present};

endmodule

`default_nettype wire
